### sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### sv/lpr_pkg.sv
// Types, status codes and helper functions of the longest-prefix router core.
// Used by the lookup cell, the top level and the checker; depends on nothing.
package lpr_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 4;
    localparam int TTL_W  = 8;
    localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_ROUTE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_FORWARD      = 3'd0,
        ST_DROP_TTL     = 3'd1,
        ST_DROP_NOROUTE = 3'd2,
        ST_ADDED        = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  net_prefix;
        logic [LEN_W-1:0]   route_length;
        logic               has_gateway;
        logic [ADDR_W-1:0]  gateway_addr;
        logic [PORT_W-1:0]  egress_port;
        logic [ADDR_W-1:0]  dest_addr;
        logic [TTL_W-1:0]   ttl_in;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [PORT_W-1:0]  out_port;
        logic [ADDR_W-1:0]  hop_addr;
        logic [TTL_W-1:0]   ttl_out;
    } t_result;

    // One stored route, as held by a cell.
    typedef struct packed {
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   len;
        logic               gw_valid;
        logic [ADDR_W-1:0]  gw;
        logic [PORT_W-1:0]  port;
    } t_route;

    // Search token handed from cell to cell; it carries the best match so far.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [LEN_W-1:0]   best_len;
        logic [PORT_W-1:0]  port;
        logic               gw_valid;
        logic [ADDR_W-1:0]  gw;
    } t_token;

    // Mask of the top len bits; len is at most 32 once stored.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

### sv/lpr_cell.sv
// One route cell of the lookup chain: stores one route and updates the passing token.
// Depends on lpr_pkg for the route and token types and the mask function.
module lpr_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [CW-1:0]               i_count,
    input  lpr_pkg::t_route             i_route,
    input  logic [lpr_pkg::ADDR_W-1:0]  i_dest,
    input  lpr_pkg::t_token             i_tok,
    output lpr_pkg::t_token             o_tok
);
    import lpr_pkg::*;

    t_route r_route;
    t_token r_tok;
    t_token n_tok;
    logic   w_used;
    logic   w_hit;

    // Only cells below the fill count hold a written route.
    assign w_used = CW'(IDX) < i_count;
    assign w_hit  = w_used && ((i_dest & len_mask(r_route.len)) == r_route.prefix);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && w_hit && (!i_tok.found || (r_route.len > i_tok.best_len))) begin
            n_tok.found    = 1'b1;
            n_tok.best_len = r_route.len;
            n_tok.port     = r_route.port;
            n_tok.gw_valid = r_route.gw_valid;
            n_tok.gw       = r_route.gw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && (i_count == CW'(IDX))) begin
            r_route <= i_route;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### sv/ipv4_longest_prefix_router_core.sv
// Top level of the IPv4 longest-prefix router core: request control, route count and cell chain.
// Depends on lpr_pkg and instantiates lpr_cell once per route entry.
//
//  Channel   Ports                    Direction  Handshake
//  request   start, busy, i_req       in         taken when start is high and busy is low
//  result    o_strobe, o_rsp          out        held for one cycle, always taken
//
// An add request and a datagram with TTL 0 or 1 answer in the cycle after acceptance, and
// busy stays low, so the next request can follow at once.
// A datagram to look up is answered once the search token, started from the launch register,
// has stepped through one cell per cycle along the whole chain; busy is high for the whole walk.
// Reset is synchronous and clears only the route count and the control state; the stored
// routes need no clearing pass. The receiver cannot stall, so there is no output backpressure.
module ipv4_longest_prefix_router_core #(
    parameter int ROUTE_ENTRIES = 32,
    parameter int PORT_COUNT    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lpr_pkg::t_request i_req,
    output logic              o_strobe,
    output lpr_pkg::t_result  o_rsp
);
    import lpr_pkg::*;

    // The count must be able to hold ROUTE_ENTRIES itself.
    localparam int CW = $clog2(ROUTE_ENTRIES + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    t_token             r_launch;
    logic [ADDR_W-1:0]  r_dest;
    logic [TTL_W-1:0]   r_ttl;
    logic               r_strobe;
    t_result            r_rsp;

    t_state             n_state;
    logic [CW-1:0]      n_count;
    t_token             n_launch;
    logic [ADDR_W-1:0]  n_dest;
    logic [TTL_W-1:0]   n_ttl;
    logic               n_strobe;
    t_result            n_rsp;

    logic               w_accept;
    logic               w_full;
    logic               w_add;
    t_route             w_route;
    t_token             w_tok [0:ROUTE_ENTRIES];
    t_result            w_lookup;

    assign w_accept = start && !busy;
    assign w_full   = r_count == CW'(ROUTE_ENTRIES);
    // A route is written into the cell whose index equals the current count.
    assign w_add    = w_accept && (i_req.op == OP_ADD) && !w_full;

    always_comb begin
        w_route.prefix   = i_req.net_prefix;
        w_route.len      = (i_req.route_length > LEN_MAX) ? LEN_MAX : i_req.route_length;
        w_route.gw_valid = i_req.has_gateway;
        w_route.gw       = i_req.gateway_addr;
        w_route.port     = i_req.egress_port;
    end

    // The chain starts from the launch register and ends at the last cell's token.
    assign w_tok[0] = r_launch;

    for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
        lpr_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_add),
            .i_count (r_count),
            .i_route (w_route),
            .i_dest  (r_dest),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Final decision once the token leaves the last cell. A winning route whose port is
    // outside the interface range counts as no route.
    always_comb begin
        w_lookup = '0;
        if (!w_tok[ROUTE_ENTRIES].found || (int'(w_tok[ROUTE_ENTRIES].port) >= PORT_COUNT)) begin
            w_lookup.status = ST_DROP_NOROUTE;
        end else begin
            w_lookup.status   = ST_FORWARD;
            w_lookup.out_port = w_tok[ROUTE_ENTRIES].port;
            w_lookup.hop_addr = w_tok[ROUTE_ENTRIES].gw_valid ? w_tok[ROUTE_ENTRIES].gw : r_dest;
            w_lookup.ttl_out  = r_ttl - 8'd1;
        end
    end

    // Next state and outputs. The strobe and the launch mark last a single cycle.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_launch       = r_launch;
        n_launch.valid = 1'b0;
        n_dest         = r_dest;
        n_ttl          = r_ttl;
        n_strobe       = 1'b0;
        n_rsp          = r_rsp;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rsp = '0;
                    if (i_req.op == OP_ADD) begin
                        n_strobe = 1'b1;
                        if (w_full) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            n_rsp.status = ST_ADDED;
                            n_count      = r_count + CW'(1);
                        end
                    end else if (i_req.ttl_in <= 8'd1) begin
                        n_strobe     = 1'b1;
                        n_rsp.status = ST_DROP_TTL;
                    end else begin
                        // Start a walk down the chain with no match yet.
                        n_dest         = i_req.dest_addr;
                        n_ttl          = i_req.ttl_in;
                        n_launch       = '0;
                        n_launch.valid = 1'b1;
                        n_state        = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_tok[ROUTE_ENTRIES].valid) begin
                    n_strobe = 1'b1;
                    n_rsp    = w_lookup;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_launch.valid <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_launch <= n_launch;
            r_dest   <= n_dest;
            r_ttl    <= n_ttl;
            r_strobe <= n_strobe;
            r_rsp    <= n_rsp;
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

### sv/lpr_checker.sv
// Port-level checker of the longest-prefix router core, bound to the top level.
// Depends on lpr_pkg and on assert_macros.svh.
`include "assert_macros.svh"

module lpr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input lpr_pkg::t_request i_req,
    input logic              o_strobe,
    input lpr_pkg::t_result  o_rsp
);
    import lpr_pkg::*;

    logic w_accept;
    logic w_quick;
    logic w_add_rsp;
    logic w_rest_zero;

    assign w_accept    = start && !busy;
    // Adds and short-TTL datagrams need no table walk.
    assign w_quick     = (i_req.op == OP_ADD) || (i_req.ttl_in <= 8'd1);
    assign w_add_rsp   = (o_rsp.status == ST_ADDED) || (o_rsp.status == ST_FULL);
    assign w_rest_zero = (o_rsp.out_port == '0) && (o_rsp.hop_addr == '0)
                         && (o_rsp.ttl_out == '0);

    `ASSERT_NEXT(a_quick_answer, i_clk, i_rst_n, w_accept && w_quick, o_strobe)
    `ASSERT_NEXT(a_walk_busy, i_clk, i_rst_n, w_accept && !w_quick, busy && !o_strobe)
    `ASSERT_IMPLY(a_add_zero, i_clk, i_rst_n, o_strobe && w_add_rsp, w_rest_zero)
    `ASSERT_IMPLY(a_fwd_ttl, i_clk, i_rst_n, o_strobe && (o_rsp.status == ST_FORWARD), o_rsp.ttl_out != '0)

endmodule

bind ipv4_longest_prefix_router_core lpr_checker u_lpr_checker (.*);

### tb/sv/tb_ipv4_longest_prefix_router_core.sv
// Self-checking testbench of the IPv4 longest-prefix router core: directed and random requests.
// Depends on lpr_pkg and ipv4_longest_prefix_router_core; predicts each result with its own table.
module tb_ipv4_longest_prefix_router_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int ROUTE_ENTRIES = 32;
    localparam int PORT_COUNT    = 16;
    localparam int RANDOM_ITEMS  = 1730;
    // A lookup walks the whole chain, and the sender may idle on top of that,
    // so a long quiet stretch means the block is stuck.
    localparam int STALL_LIMIT   = 4000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_request i_req   = '0;
    logic     o_strobe;
    t_result  o_rsp;

    ipv4_longest_prefix_router_core #(
        .ROUTE_ENTRIES(ROUTE_ENTRIES),
        .PORT_COUNT   (PORT_COUNT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Requests waiting to be driven, and the decisions the block owes us, in order.
    t_request request_q[$];
    t_result  decision_q[$];

    int total_items    = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int stall_cycles   = 0;

    // The testbench's own copy of the route table.
    logic [31:0] rt_prefix_tbl[ROUTE_ENTRIES];
    logic [5:0]  route_len_tbl[ROUTE_ENTRIES];
    logic        route_gw_valid_tbl[ROUTE_ENTRIES];
    logic [31:0] route_gw_tbl[ROUTE_ENTRIES];
    logic [3:0]  route_port_tbl[ROUTE_ENTRIES];
    int          route_count = 0;

    // Routes as the stimulus generator believes them, used to aim destinations.
    logic [31:0] aim_prefix_q[$];
    int          aim_len_q[$];

    // Mask that keeps the top len bits of an address.
    function automatic logic [31:0] prefix_mask(input int len);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++) begin
            if (b < len) begin
                m[31-b] = 1'b1;
            end
        end
        return m;
    endfunction

    // Computes the block's answer to one accepted request and updates the table.
    function automatic t_result forward_decision(input t_request req);
        t_result     res;
        int          best;
        bit          hit;
        logic [5:0]  len;
        res  = '0;
        best = 0;
        hit  = 1'b0;
        if (req.op == OP_ADD) begin
            if (route_count >= ROUTE_ENTRIES) begin
                res.status = ST_FULL;
            end else begin
                // Lengths above 32 are stored as 32.
                len = (req.route_length > 6'd32) ? 6'd32 : req.route_length;
                rt_prefix_tbl[route_count]      = req.net_prefix;
                route_len_tbl[route_count]      = len;
                route_gw_valid_tbl[route_count] = req.has_gateway;
                route_gw_tbl[route_count]       = req.gateway_addr;
                route_port_tbl[route_count]     = req.egress_port;
                route_count++;
                res.status = ST_ADDED;
            end
        end else if (req.ttl_in <= 8'd1) begin
            // Expiring datagrams are dropped before any lookup.
            res.status = ST_DROP_TTL;
        end else begin
            for (int i = 0; i < route_count; i++) begin
                if ((req.dest_addr & prefix_mask(route_len_tbl[i])) == rt_prefix_tbl[i]) begin
                    // Strictly longer wins, so the earliest entry keeps a tie.
                    if (!hit || route_len_tbl[i] > route_len_tbl[best]) begin
                        best = i;
                        hit  = 1'b1;
                    end
                end
            end
            if (!hit || int'(route_port_tbl[best]) >= PORT_COUNT) begin
                res.status = ST_DROP_NOROUTE;
            end else begin
                res.status   = ST_FORWARD;
                res.out_port = route_port_tbl[best];
                res.hop_addr = route_gw_valid_tbl[best] ? route_gw_tbl[best] : req.dest_addr;
                res.ttl_out  = req.ttl_in - 8'd1;
            end
        end
        return res;
    endfunction

    // Queues an add request; the datagram fields carry noise the block must ignore.
    task automatic queue_add(input logic [31:0] prefix, input logic [5:0] len,
                             input logic gw_valid, input logic [31:0] gw,
                             input logic [3:0] port);
        t_request req;
        req.op           = OP_ADD;
        req.net_prefix   = prefix;
        req.route_length = len;
        req.has_gateway  = gw_valid;
        req.gateway_addr = gw;
        req.egress_port  = port;
        req.dest_addr    = $urandom;
        req.ttl_in       = 8'($urandom_range(255));
        request_q.insert(request_q.size(), req);
        aim_prefix_q.insert(aim_prefix_q.size(), prefix);
        aim_len_q.insert(aim_len_q.size(), (len > 6'd32) ? 32 : int'(len));
    endtask

    // Queues a datagram; the route fields carry noise the block must ignore.
    task automatic queue_datagram(input logic [31:0] dest, input logic [7:0] ttl);
        t_request req;
        req.op           = OP_ROUTE;
        req.net_prefix   = $urandom;
        req.route_length = 6'($urandom_range(63));
        req.has_gateway  = 1'($urandom_range(1));
        req.gateway_addr = $urandom;
        req.egress_port  = 4'($urandom_range(15));
        req.dest_addr    = dest;
        req.ttl_in       = ttl;
        request_q.insert(request_q.size(), req);
    endtask

    // Driver: a request leaves the queue when it is driven, and its expected
    // decision is computed at the edge where the block takes it. A request
    // that is waiting on busy is held unchanged.
    always @(posedge i_clk) begin : drive
        int idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) begin
                decision_q.insert(decision_q.size(), forward_decision(i_req));
                accepted_count++;
            end
            // Sender idles a third of the time first, then more than half, then never.
            if (accepted_count < total_items / 3) begin
                idle_pct = 33;
            end else if (accepted_count < (2 * total_items) / 3) begin
                idle_pct = 55;
            end else begin
                idle_pct = 0;
            end
            if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_req <= request_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe is checked against the oldest expected decision.
    // It also counts cycles in which no request is accepted.
    always @(posedge i_clk) begin : watch
        t_result exp_res;
        if (i_rst_n && o_strobe) begin
            if (decision_q.size() == 0) begin
                $error("unexpected result: status %0d out_port %0d hop_addr %h ttl_out %0d",
                       o_rsp.status, o_rsp.out_port, o_rsp.hop_addr, o_rsp.ttl_out);
                error_count++;
            end else begin
                exp_res = decision_q.pop_front();
                if (o_rsp.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_rsp.status);
                    error_count++;
                end
                if (o_rsp.out_port !== exp_res.out_port) begin
                    $error("out_port: expected %0d, got %0d", exp_res.out_port, o_rsp.out_port);
                    error_count++;
                end
                if (o_rsp.hop_addr !== exp_res.hop_addr) begin
                    $error("hop_addr: expected %h, got %h", exp_res.hop_addr, o_rsp.hop_addr);
                    error_count++;
                end
                if (o_rsp.ttl_out !== exp_res.ttl_out) begin
                    $error("ttl_out: expected %0d, got %0d", exp_res.ttl_out, o_rsp.ttl_out);
                    error_count++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] base;
        logic [31:0] dest;
        logic [31:0] prefix;
        logic [5:0]  len;
        logic [7:0]  ttl;
        int          sat_len;
        int          pick;
        int          default_at;
        bit          timed_out;

        // Directed part. The table starts empty, so the first datagram finds no route.
        queue_datagram(32'h0A00_0001, 8'd64);
        // Expiring datagrams: TTL 0 and TTL 1.
        queue_datagram(32'h0A00_0001, 8'd0);
        queue_datagram(32'h0A00_0001, 8'd1);
        // Host route with every prefix bit set, the highest port and a next hop.
        queue_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0102_0304, 4'd15);
        queue_datagram(32'hFFFF_FFFF, 8'd255);
        // Length 63 is stored as a host route.
        queue_add(32'h0A00_0001, 6'd63, 1'b0, 32'hDEAD_BEEF, 4'd3);
        queue_add(32'h0A00_0000, 6'd8,  1'b0, 32'h0000_0000, 4'd0);
        queue_add(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 4'd9);
        // Nested routes: the longest match must win in each case.
        queue_datagram(32'h0A01_0203, 8'd2);
        queue_datagram(32'h0A02_0304, 8'd100);
        queue_datagram(32'h0A00_0001, 8'd10);
        // A duplicate /8 ties with the earlier one, which must keep winning.
        queue_add(32'h0A00_0000, 6'd8, 1'b1, 32'h0505_0505, 4'd7);
        queue_datagram(32'h0AFF_FFFF, 8'd9);
        // Prefixes with bits set below their length can never match.
        queue_add(32'h0A00_0001, 6'd8, 1'b1, 32'h0606_0606, 4'd5);
        queue_add(32'h0000_0001, 6'd0, 1'b1, 32'h0707_0707, 4'd6);
        // A direct /1 whose gateway address must be ignored.
        queue_add(32'h8000_0000, 6'd1, 1'b0, 32'hFFFF_FFFF, 4'd2);
        queue_datagram(32'h0000_0000, 8'd2);
        queue_datagram(32'h8000_0000, 8'd3);
        queue_datagram(32'h0B00_0000, 8'd200);
        queue_datagram(32'hFFFF_FFFE, 8'd33);
        // All-zero host route with an all-zero next hop.
        queue_add(32'h0000_0000, 6'd32, 1'b1, 32'h0000_0000, 4'd4);
        queue_datagram(32'h0000_0000, 8'd255);

        // Random part. The table fills early; a true default route is queued two
        // thirds of the way through, when the table is full, so it is refused, and
        // misses get plenty of traffic. Late adds exercise the full table.
        default_at = (2 * RANDOM_ITEMS) / 3;
        for (int r = 0; r < RANDOM_ITEMS; r++) begin
            if (r == default_at) begin
                queue_add(32'h0000_0000, 6'd0, 1'($urandom_range(1)), $urandom,
                          4'($urandom_range(15)));
            end else if ($urandom_range(99) < ((aim_prefix_q.size() < ROUTE_ENTRIES - 1) ? 30 : 3)) begin
                pick = $urandom_range(9);
                if (pick < 8) begin
                    len = 6'($urandom_range(1, 32));
                end else if (pick == 8) begin
                    len = 6'($urandom_range(33, 63));
                end else begin
                    len = 6'd0;
                end
                sat_len = (len > 6'd32) ? 32 : int'(len);
                // Half the time nest the new route under or beside an existing one.
                if (aim_prefix_q.size() > 0 && $urandom_range(1) == 1) begin
                    base = aim_prefix_q[$urandom_range(aim_prefix_q.size() - 1)]
                           ^ ($urandom >> $urandom_range(8, 31));
                end else begin
                    base = $urandom;
                end
                if (len == 6'd0) begin
                    prefix = base | 32'h1;
                end else if ($urandom_range(9) != 0) begin
                    prefix = base & prefix_mask(sat_len);
                end else begin
                    prefix = base;
                end
                queue_add(prefix, len, 1'($urandom_range(1)), $urandom,
                          4'($urandom_range(15)));
            end else begin
                ttl = ($urandom_range(9) == 0) ? 8'($urandom_range(1)) : 8'($urandom_range(2, 255));
                if (aim_prefix_q.size() > 0 && $urandom_range(99) < 75) begin
                    pick = $urandom_range(aim_prefix_q.size() - 1);
                    dest = (aim_prefix_q[pick] & prefix_mask(aim_len_q[pick]))
                           | ($urandom & ~prefix_mask(aim_len_q[pick]));
                    // Near misses: one flipped bit may fall inside the prefix.
                    if ($urandom_range(99) < 15) begin
                        dest[5'($urandom_range(31))] ^= 1'b1;
                    end
                end else begin
                    dest = $urandom;
                end
                queue_datagram(dest, ttl);
            end
        end
        total_items = request_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken and answered, or the block stalls.
        timed_out = 1'b0;
        while (!(request_q.size() == 0 && !start && decision_q.size() == 0)) begin
            @(negedge i_clk);
            if (stall_cycles >= STALL_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end

        if (timed_out) begin
            $display("tb_ipv4_longest_prefix_router_core NOT OK");
        end else begin
            // Let a stray late strobe show up before the verdict.
            repeat (ROUTE_ENTRIES + 8) @(negedge i_clk);
            if (error_count == 0 && decision_q.size() == 0) begin
                $display("tb_ipv4_longest_prefix_router_core OK");
            end else begin
                $display("tb_ipv4_longest_prefix_router_core NOT OK");
            end
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/lpr_pkg.sv
sv/lpr_cell.sv
sv/ipv4_longest_prefix_router_core.sv
sv/lpr_checker.sv
tb/sv/tb_ipv4_longest_prefix_router_core.sv
